FILE: rtl/mandelbrot_escape_time_core_macros.svh
// Assertion helpers shared by the escape time pipeline.
// Each use expects clk and arst_n in scope at the point of use.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mbe_pkg.sv
package mbe_pkg;

	// Default build parameters.
	localparam int MAX_DEPTH_DEF = 64;
	localparam int FRAC_BITS_DEF = 28;

	// Fixed field widths.
	localparam int COORD_W    = 32;
	localparam int STEP_W     = 31;
	localparam int POS_W      = 10;
	localparam int ITER_W     = 7;
	localparam int COUNT_W    = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register reset values (Q4.28 window around the classic view).
	localparam logic signed [COORD_W-1:0] X_START_RST  = 32'shD8000000;
	localparam logic signed [COORD_W-1:0] Y_TOP_RST    = 32'sh18000000;
	localparam logic [STEP_W-1:0]         X_STEP_RST   = 31'd918443;
	localparam logic [STEP_W-1:0]         Y_STEP_RST   = 31'd787237;
	localparam logic [ITER_W-1:0]         MAX_ITER_RST = 7'd20;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_X_START  = 3'd0,
		REG_Y_TOP    = 3'd1,
		REG_X_STEP   = 3'd2,
		REG_Y_STEP   = 3'd3,
		REG_MAX_ITER = 3'd4
	} cfg_reg_t;

	// Per-item control bits that travel down the pipeline.
	typedef struct packed {
		logic valid;
		logic done;
	} iter_ctl_t;

	// Iterate and point of one pixel.
	typedef struct packed {
		logic signed [COORD_W-1:0] zr;
		logic signed [COORD_W-1:0] zi;
		logic signed [COORD_W-1:0] cr;
		logic signed [COORD_W-1:0] ci;
	} point_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
		logic signed [COORD_W-1:0] r;
		if ((&v[65:31]) || !(|v[65:31])) begin
			r = v[31:0];
		end else if (v[65]) begin
			r = 32'sh80000000;
		end else begin
			r = 32'sh7FFFFFFF;
		end
		return r;
	endfunction

endpackage

FILE: rtl/mbe_coord.sv
module mbe_coord (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   take,
	input  logic [mbe_pkg::POS_W-1:0]              column,
	input  logic [mbe_pkg::POS_W-1:0]              row,
	input  logic signed [mbe_pkg::COORD_W-1:0]     x_start,
	input  logic signed [mbe_pkg::COORD_W-1:0]     y_top,
	input  logic [mbe_pkg::STEP_W-1:0]             x_step,
	input  logic [mbe_pkg::STEP_W-1:0]             y_step,
	output mbe_pkg::iter_ctl_t                     out_ctl,
	output mbe_pkg::point_t                        out_pt
);

	localparam int PROD_W = mbe_pkg::POS_W + mbe_pkg::STEP_W;

	logic              valid_s1;
	logic [PROD_W-1:0] xoff_s1;
	logic [PROD_W-1:0] yoff_s1;
	mbe_pkg::iter_ctl_t ctl_s2;
	mbe_pkg::point_t    pt_s2;
	logic signed [65:0] cr_sum;
	logic signed [65:0] ci_sum;

	// First stage: scale the pixel position by the step sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xoff_s1 <= PROD_W'(column) * PROD_W'(x_step);
			yoff_s1 <= PROD_W'(row) * PROD_W'(y_step);
		end
	end

	// Second stage: offset from the window edges and saturate.
	always_comb begin
		cr_sum = 66'(x_start) + $signed({{(66-PROD_W){1'b0}}, xoff_s1});
		ci_sum = 66'(y_top) - $signed({{(66-PROD_W){1'b0}}, yoff_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.done  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2.zr <= '0;
			pt_s2.zi <= '0;
			pt_s2.cr <= mbe_pkg::sat32(cr_sum);
			pt_s2.ci <= mbe_pkg::sat32(ci_sum);
		end
	end

	assign out_ctl = ctl_s2;
	assign out_pt  = pt_s2;

endmodule

FILE: rtl/mbe_iter.sv
`include "mandelbrot_escape_time_core_macros.svh"

module mbe_iter #(
	parameter int MAX_DEPTH = mbe_pkg::MAX_DEPTH_DEF,
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF,
	localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [DEPTH_W-1:0] limit,
	input  mbe_pkg::iter_ctl_t in_ctl,
	input  mbe_pkg::point_t    in_pt,
	input  logic [DEPTH_W-1:0] in_depth,
	output mbe_pkg::iter_ctl_t out_ctl,
	output mbe_pkg::point_t    out_pt,
	output logic [DEPTH_W-1:0] out_depth
);

	// Escape bound 4.0 at twice the fraction bits; unrepresentable means no escape.
	localparam int          ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam bit          NEVER_ESC = (ESC_SHIFT >= 64);
	localparam logic [63:0] ESC_BOUND = NEVER_ESC ? 64'd0 : (64'd1 << ESC_SHIFT);

	mbe_pkg::iter_ctl_t        ctl_s1;
	logic signed [63:0]        rr_s1;
	logic signed [63:0]        ii_s1;
	logic signed [63:0]        ri_s1;
	logic signed [31:0]        cr_s1;
	logic signed [31:0]        ci_s1;
	logic [DEPTH_W-1:0]        depth_s1;

	mbe_pkg::iter_ctl_t        ctl_s2;
	mbe_pkg::point_t           pt_s2;
	logic [DEPTH_W-1:0]        depth_s2;

	logic [63:0]               mag;
	logic                      in_radius;
	logic                      go;
	logic signed [64:0]        re_diff;
	logic signed [64:0]        re_sh;
	logic signed [63:0]        im_sh;
	logic signed [65:0]        re_sum;
	logic signed [65:0]        im_sum;

	// Multiply stage: the three products of the current iterate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1    <= 64'($signed(in_pt.zr)) * 64'($signed(in_pt.zr));
			ii_s1    <= 64'($signed(in_pt.zi)) * 64'($signed(in_pt.zi));
			ri_s1    <= 64'($signed(in_pt.zr)) * 64'($signed(in_pt.zi));
			cr_s1    <= in_pt.cr;
			ci_s1    <= in_pt.ci;
			depth_s1 <= in_depth;
		end
	end

	// Update stage: escape test, then the next iterate with saturation.
	always_comb begin
		mag       = $unsigned(rr_s1) + $unsigned(ii_s1);
		in_radius = NEVER_ESC || (mag <= ESC_BOUND);
		go        = !ctl_s1.done && in_radius && (depth_s1 < limit);
		re_diff   = 65'(rr_s1) - 65'(ii_s1);
		re_sh     = re_diff >>> FRAC_BITS;
		im_sh     = ri_s1 >>> (FRAC_BITS - 1);
		re_sum    = 66'(re_sh) + 66'(cr_s1);
		im_sum    = 66'(im_sh) + 66'(ci_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.done  <= !go;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2.zr <= mbe_pkg::sat32(re_sum);
			pt_s2.zi <= mbe_pkg::sat32(im_sum);
			pt_s2.cr <= cr_s1;
			pt_s2.ci <= ci_s1;
			depth_s2 <= go ? (depth_s1 + DEPTH_W'(1)) : depth_s1;
		end
	end

	assign out_ctl   = ctl_s2;
	assign out_pt    = pt_s2;
	assign out_depth = depth_s2;

	// A finished pixel keeps its count through the stage.
	`MBE_ASSERT_NXT(a_done_holds, en && ctl_s1.valid && ctl_s1.done, ctl_s2.done && (depth_s2 == $past(depth_s1)), "finished pixel changed its count")
	// A pixel at the limit cannot iterate again.
	`MBE_ASSERT_NXT(a_limit_stops, en && ctl_s1.valid && (depth_s1 >= limit), ctl_s2.done, "pixel iterated past the limit")
	// A pixel still running has done at least one iteration here.
	`MBE_ASSERT_IMP(a_running_counted, ctl_s2.valid && !ctl_s2.done, depth_s2 != '0, "running pixel with zero count")

endmodule

FILE: rtl/mbe_outbuf.sv
`include "mandelbrot_escape_time_core_macros.svh"

module mbe_outbuf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pipe_valid,
	input  logic [mbe_pkg::COUNT_W-1:0]    pipe_count,
	output logic                           en,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [mbe_pkg::COUNT_W-1:0]    escape_count
);

	logic                        res_valid_q;
	logic                        skid_valid_q;
	logic [mbe_pkg::COUNT_W-1:0] res_count_q;
	logic [mbe_pkg::COUNT_W-1:0] skid_count_q;

	// The pipeline advances only while the skid register is free.
	assign en = !skid_valid_q;

	// Output register plus one skid entry for a result caught by a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!res_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (pipe_valid) begin
			if (res_valid_q && res_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!res_stall) begin
				res_count_q <= skid_count_q;
			end
		end else if (pipe_valid) begin
			if (res_valid_q && res_stall) begin
				skid_count_q <= pipe_count;
			end else begin
				res_count_q <= pipe_count;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign escape_count = res_count_q;

	// The skid entry is only ever filled behind a waiting result.
	`MBE_ASSERT_IMP(a_skid_behind_res, skid_valid_q, res_valid_q, "skid entry without an output result")
	// A new result arriving at a stalled output lands in the skid entry.
	`MBE_ASSERT_NXT(a_skid_catches, res_valid_q && res_stall && !skid_valid_q && pipe_valid, skid_valid_q, "stalled result was dropped")
	// Draining the skid entry keeps a result on the output.
	`MBE_ASSERT_NXT(a_skid_drains, skid_valid_q && !res_stall, res_valid_q && !skid_valid_q, "skid entry not moved to the output")

endmodule

FILE: rtl/mandelbrot_escape_time_core.sv
// Mandelbrot escape time evaluator, one pixel per request.
// Pixel channel: pix_valid/pix_stall with column and row. A request is taken
// at a clock edge where pix_valid is high and pix_stall is low.
// Result channel: res_valid/res_stall with escape_count, the number of
// iterations before |z|^2 exceeded 4, or 0 when the iteration limit was hit.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Registers: 0 x_start, 1 y_top, 2 x_step, 3 y_step, 4 max_iter.
// Write them only while no pixel is in flight.
// Throughput: one pixel per clock while pix_stall is low. res_valid follows
// the accepting edge through the register stages: two to form the point,
// then MAX_DEPTH unrolled iteration units of two stages each (multiply,
// then update), then the output register.
// When res_stall holds a result, one more result is caught in a skid entry;
// pix_stall then rises and the whole pipeline freezes until it drains.
// Reset clears all valid bits and loads the default window and limit.
module mandelbrot_escape_time_core #(
	parameter int MAX_DEPTH = mbe_pkg::MAX_DEPTH_DEF,
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic [mbe_pkg::POS_W-1:0]           column,
	input  logic [mbe_pkg::POS_W-1:0]           row,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [mbe_pkg::COUNT_W-1:0]         escape_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

	logic signed [mbe_pkg::COORD_W-1:0] x_start_q;
	logic signed [mbe_pkg::COORD_W-1:0] y_top_q;
	logic [mbe_pkg::STEP_W-1:0]         x_step_q;
	logic [mbe_pkg::STEP_W-1:0]         y_step_q;
	logic [mbe_pkg::ITER_W-1:0]         max_iter_q;

	logic [31:0]                 mi32;
	logic [31:0]                 limit32;
	logic [DEPTH_W-1:0]          limit;
	logic                        en;

	mbe_pkg::iter_ctl_t          ctl_chain   [0:MAX_DEPTH];
	mbe_pkg::point_t             pt_chain    [0:MAX_DEPTH];
	logic [DEPTH_W-1:0]          depth_chain [0:MAX_DEPTH];

	logic [DEPTH_W-1:0]          last_depth;
	logic [31:0]                 last32;
	logic [31:0]                 count32;

	// Configuration registers; writes to unused indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q  <= mbe_pkg::X_START_RST;
			y_top_q    <= mbe_pkg::Y_TOP_RST;
			x_step_q   <= mbe_pkg::X_STEP_RST;
			y_step_q   <= mbe_pkg::Y_STEP_RST;
			max_iter_q <= mbe_pkg::MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (mbe_pkg::cfg_reg_t'(cfg_index))
				mbe_pkg::REG_X_START: begin
					x_start_q <= cfg_data;
				end
				mbe_pkg::REG_Y_TOP: begin
					y_top_q <= cfg_data;
				end
				mbe_pkg::REG_X_STEP: begin
					x_step_q <= cfg_data[mbe_pkg::STEP_W-1:0];
				end
				mbe_pkg::REG_Y_STEP: begin
					y_step_q <= cfg_data[mbe_pkg::STEP_W-1:0];
				end
				mbe_pkg::REG_MAX_ITER: begin
					max_iter_q <= cfg_data[mbe_pkg::ITER_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Iteration limit clamped to 1..MAX_DEPTH.
	always_comb begin
		mi32 = 32'(max_iter_q);
		if (mi32 == 32'd0) begin
			limit32 = 32'd1;
		end else if (mi32 > 32'(MAX_DEPTH)) begin
			limit32 = 32'(MAX_DEPTH);
		end else begin
			limit32 = mi32;
		end
		limit = limit32[DEPTH_W-1:0];
	end

	assign pix_stall = !en;

	// Point formation.
	mbe_coord u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.take    (pix_valid),
		.column  (column),
		.row     (row),
		.x_start (x_start_q),
		.y_top   (y_top_q),
		.x_step  (x_step_q),
		.y_step  (y_step_q),
		.out_ctl (ctl_chain[0]),
		.out_pt  (pt_chain[0])
	);

	assign depth_chain[0] = '0;

	// Unrolled iteration units.
	for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_iter
		mbe_iter #(
			.MAX_DEPTH (MAX_DEPTH),
			.FRAC_BITS (FRAC_BITS)
		) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.limit     (limit),
			.in_ctl    (ctl_chain[k]),
			.in_pt     (pt_chain[k]),
			.in_depth  (depth_chain[k]),
			.out_ctl   (ctl_chain[k+1]),
			.out_pt    (pt_chain[k+1]),
			.out_depth (depth_chain[k+1])
		);
	end

	// A pixel that reached the limit reports zero.
	always_comb begin
		last_depth = depth_chain[MAX_DEPTH];
		last32     = 32'(last_depth);
		count32    = (last_depth < limit) ? last32 : 32'd0;
	end

	mbe_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.pipe_valid   (ctl_chain[MAX_DEPTH].valid),
		.pipe_count   (count32[mbe_pkg::COUNT_W-1:0]),
		.en           (en),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.escape_count (escape_count)
	);

endmodule
